// ----- src/tmth_pkg.sv -----
`timescale 1ns / 1ps

package tmth_pkg;

  localparam int SC_W       = 7;
  localparam int CAL_RAW_W  = 12;
  localparam int TEMP_W     = 16;
  localparam int THR_W      = 15;
  localparam int OUT_RAW_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_COUNT  = 3;

  localparam logic [SC_W-1:0]      RST_SAMPLE_COUNT = 7'd10;
  localparam logic [CAL_RAW_W-1:0] RST_CAL_LOW_RAW  = 12'd3269;
  localparam logic [TEMP_W-1:0]    RST_CAL_LOW_TEMP = 16'd2222;
  localparam logic [CAL_RAW_W-1:0] RST_CAL_HIGH_RAW = 12'd3811;
  localparam logic [TEMP_W-1:0]    RST_CAL_HIGH_TEMP = 16'd2900;
  localparam logic [THR_W-1:0]     RST_THRESHOLD    = 15'd4;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT  = 3'd0,
    REG_CAL_LOW_RAW   = 3'd1,
    REG_CAL_LOW_TEMP  = 3'd2,
    REG_CAL_HIGH_RAW  = 3'd3,
    REG_CAL_HIGH_TEMP = 3'd4,
    REG_THRESHOLD     = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_TRIM,
    ST_DIV1,
    ST_WAIT1,
    ST_MUL,
    ST_MAG,
    ST_DIV2,
    ST_WAIT2,
    ST_SAT,
    ST_REPORT
  } state_t;

endpackage

// ----- src/tmth_div.sv -----
`timescale 1ns / 1ps

module tmth_div import tmth_pkg::*; #(
  parameter int DVD_W = 29,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int ITER_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0]  rem;
  logic [DVD_W-1:0]  quo;
  logic [ITER_W-1:0] iter;
  logic              busy;
  logic [DVS_W:0]    shifted;
  logic [DVS_W+1:0]  diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
    ge      = !diff[DVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(DVD_W);
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem  <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo  <= {quo[DVD_W-2:0], ge};
        iter <= iter - ITER_W'(1);
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- src/trimmed_mean_two_point_thermometer.sv -----
`timescale 1ns / 1ps

// Trimmed-mean thermometer. Each adc_sample request is folded into a running
// sum, minimum and maximum. The last sample of a block (sample_count samples,
// clamped to 3..MAX_SAMPLES) starts the end-of-block sequence, during which
// in_ready is low: the trimmed mean (sum minus min and max, over count minus 2)
// and, unless the calibration raws are equal, the calibration quotient are
// taken by one shared restoring divider at one bit per cycle, with a single
// multiply between them. The sequence ends by waiting while the previous result
// is still held at the output; in_ready is high in all other states. One result
// request is produced per block and held in an output register, so the next
// block's samples are taken while it waits.
// Configuration writes are always accepted and must only be issued while the
// block is idle.

module trimmed_mean_two_point_thermometer import tmth_pkg::*; #(
  parameter int MAX_SAMPLES = 64,
  parameter int ADC_BITS    = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ADC_BITS-1:0]          adc_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [OUT_RAW_W-1:0]         average_raw,
  output logic signed [TEMP_W-1:0]     temperature_centi,
  output logic                         report,
  output logic                         saturated,
  output logic                         calibration_invalid
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = ADC_BITS + CNT_W;
  localparam int RAW_W  = (ADC_BITS > CAL_RAW_W) ? ADC_BITS : CAL_RAW_W;
  localparam int D_W    = RAW_W + 1;
  localparam int CD_W   = TEMP_W + 1;
  localparam int PROD_W = D_W + CD_W;
  localparam int MAG_W  = PROD_W - 1;
  localparam int DVD_W  = (MAG_W > SUM_W) ? MAG_W : SUM_W;
  localparam int DVS_W  = (CAL_RAW_W > CNT_W) ? CAL_RAW_W : CNT_W;
  localparam int NW     = (CNT_W > SC_W) ? CNT_W : SC_W;
  localparam int T_W    = DVD_W + 2;
  localparam int RD_W   = CAL_RAW_W + 1;

  state_t state, state_next;

  logic [SC_W-1:0]             sample_count;
  logic [CAL_RAW_W-1:0]        cal_low_raw;
  logic signed [TEMP_W-1:0]    cal_low_temp;
  logic [CAL_RAW_W-1:0]        cal_high_raw;
  logic signed [TEMP_W-1:0]    cal_high_temp;
  logic [THR_W-1:0]            report_threshold;

  logic [CNT_W-1:0]            block_counter;
  logic [SUM_W-1:0]            running_sum;
  logic [ADC_BITS-1:0]         block_minimum;
  logic [ADC_BITS-1:0]         block_maximum;
  logic signed [TEMP_W-1:0]    last_reported_temp;

  logic [DVD_W-1:0]            dvd;
  logic [DVS_W-1:0]            dvs;
  logic [DVD_W-1:0]            quotient;
  logic                        div_start;
  logic                        div_done;

  logic [ADC_BITS-1:0]         avg;
  logic signed [PROD_W-1:0]    prod;
  logic                        q_neg;
  logic signed [TEMP_W-1:0]    temp;
  logic                        sat;
  logic                        inval;

  logic                        in_acc;
  logic                        out_load;
  logic [NW-1:0]               sc_ext;
  logic [NW-1:0]               n_eff;
  logic [CNT_W-1:0]            taken;
  logic                        block_end;
  logic signed [D_W-1:0]       d;
  logic signed [CD_W-1:0]      cd;
  logic signed [RD_W-1:0]      rd;
  logic [PROD_W-1:0]           prod_abs;
  logic [RD_W-1:0]             rd_abs;
  logic signed [DVD_W:0]       q_s;
  logic signed [T_W-1:0]       t_wide;
  logic signed [TEMP_W:0]      diff;
  logic [TEMP_W:0]             diff_abs;
  logic                        rep;

  tmth_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quotient)
  );

  assign cfg_ready = 1'b1;

  always_comb begin
    sc_ext = NW'(sample_count);
    if (sc_ext < NW'(MIN_COUNT)) begin
      n_eff = NW'(MIN_COUNT);
    end else if (sc_ext > NW'(MAX_SAMPLES)) begin
      n_eff = NW'(MAX_SAMPLES);
    end else begin
      n_eff = sc_ext;
    end
    taken     = block_counter + CNT_W'(1);
    block_end = NW'(taken) >= n_eff;

    d        = D_W'(avg) - D_W'(cal_low_raw);
    cd       = CD_W'(cal_high_temp) - CD_W'(cal_low_temp);
    rd       = RD_W'(cal_high_raw) - RD_W'(cal_low_raw);
    prod_abs = prod[PROD_W-1] ? -prod : prod;
    rd_abs   = rd[RD_W-1] ? -rd : rd;
    q_s      = q_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    t_wide   = T_W'(cal_low_temp) + T_W'(q_s);

    diff     = (TEMP_W+1)'(temp) - (TEMP_W+1)'(last_reported_temp);
    diff_abs = diff[TEMP_W] ? -diff : diff;
    rep      = diff_abs >= (TEMP_W+1)'(report_threshold);
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid && block_end) begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM: state_next = ST_DIV1;
      ST_DIV1: begin
        div_start  = 1'b1;
        state_next = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (div_done) begin
          state_next = (cal_high_raw == cal_low_raw) ? ST_REPORT : ST_MUL;
        end
      end
      ST_MUL: state_next = ST_MAG;
      ST_MAG: state_next = ST_DIV2;
      ST_DIV2: begin
        div_start  = 1'b1;
        state_next = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (div_done) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: state_next = ST_REPORT;
      ST_REPORT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_ACC;
        end
      end
      default: state_next = ST_ACC;
    endcase
  end

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count     <= RST_SAMPLE_COUNT;
      cal_low_raw      <= RST_CAL_LOW_RAW;
      cal_low_temp     <= RST_CAL_LOW_TEMP;
      cal_high_raw     <= RST_CAL_HIGH_RAW;
      cal_high_temp    <= RST_CAL_HIGH_TEMP;
      report_threshold <= RST_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_COUNT:  sample_count     <= cfg_data[SC_W-1:0];
        REG_CAL_LOW_RAW:   cal_low_raw      <= cfg_data[CAL_RAW_W-1:0];
        REG_CAL_LOW_TEMP:  cal_low_temp     <= cfg_data;
        REG_CAL_HIGH_RAW:  cal_high_raw     <= cfg_data[CAL_RAW_W-1:0];
        REG_CAL_HIGH_TEMP: cal_high_temp    <= cfg_data;
        REG_THRESHOLD:     report_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      running_sum   <= '0;
      block_minimum <= '1;
      block_maximum <= '0;
    end else if (in_acc) begin
      block_counter <= taken;
      running_sum   <= running_sum + SUM_W'(adc_sample);
      if (adc_sample < block_minimum) begin
        block_minimum <= adc_sample;
      end
      if (adc_sample > block_maximum) begin
        block_maximum <= adc_sample;
      end
    end else if (state == ST_TRIM) begin
      block_counter <= '0;
      running_sum   <= '0;
      block_minimum <= '1;
      block_maximum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_TRIM: begin
        dvd <= DVD_W'(running_sum - SUM_W'(block_minimum) - SUM_W'(block_maximum));
        dvs <= DVS_W'(block_counter - CNT_W'(2));
      end
      ST_WAIT1: begin
        if (div_done) begin
          avg   <= quotient[ADC_BITS-1:0];
          temp  <= cal_low_temp;
          sat   <= 1'b0;
          inval <= (cal_high_raw == cal_low_raw);
        end
      end
      ST_MUL: prod <= PROD_W'(d) * PROD_W'(cd);
      ST_MAG: begin
        dvd   <= DVD_W'(prod_abs);
        dvs   <= DVS_W'(rd_abs);
        q_neg <= prod[PROD_W-1] ^ rd[RD_W-1];
      end
      ST_SAT: begin
        if (t_wide > T_W'(TEMP_MAX)) begin
          temp <= TEMP_MAX;
          sat  <= 1'b1;
        end else if (t_wide < T_W'(TEMP_MIN)) begin
          temp <= TEMP_MIN;
          sat  <= 1'b1;
        end else begin
          temp <= t_wide[TEMP_W-1:0];
          sat  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      last_reported_temp <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        if (rep) begin
          last_reported_temp <= temp;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average_raw         <= OUT_RAW_W'(avg);
      temperature_centi   <= temp;
      report              <= rep;
      saturated           <= sat;
      calibration_invalid <= inval;
    end
  end

endmodule

// ----- src/tmth_chk.sv -----
`timescale 1ns / 1ps

module tmth_chk import tmth_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [OUT_RAW_W-1:0]     average_raw,
  input logic signed [TEMP_W-1:0] temperature_centi,
  input logic                     report,
  input logic                     saturated,
  input logic                     calibration_invalid
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature_centi)
      && $stable(average_raw) && $stable(report) && $stable(saturated)
      && $stable(calibration_invalid))
    else $error("result changed while stalled");

  // a new result always comes out of the end-of-block sequence
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without end-of-block processing");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      temperature_centi == TEMP_MAX || temperature_centi == TEMP_MIN)
    else $error("saturated result not at a rail");

  a_inval_nosat: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibration_invalid |-> !saturated)
    else $error("invalid calibration flagged as saturated");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind trimmed_mean_two_point_thermometer tmth_chk u_tmth_chk (
  .clk                 (clk),
  .rst                 (rst),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .average_raw         (average_raw),
  .temperature_centi   (temperature_centi),
  .report              (report),
  .saturated           (saturated),
  .calibration_invalid (calibration_invalid)
);

// ----- sim/thermo_checker.sv -----
`timescale 1ns / 1ps

module thermo_checker import tmth_pkg::*; #(
  parameter int MAX_SAMPLES = 64,
  parameter int ADC_BITS    = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [ADC_BITS-1:0]      adc_sample,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [OUT_RAW_W-1:0]     average_raw,
  input  logic signed [TEMP_W-1:0] temperature_centi,
  input  logic                     report,
  input  logic                     saturated,
  input  logic                     calibration_invalid,
  output int unsigned              mismatches,
  output int unsigned              outstanding
);

  typedef struct packed {
    logic [OUT_RAW_W-1:0] average_raw;
    logic [TEMP_W-1:0]    temperature_centi;
    logic                 report;
    logic                 saturated;
    logic                 calibration_invalid;
  } reading_t;

  logic [SC_W-1:0]          sample_count_r;
  logic [CAL_RAW_W-1:0]     low_raw_r;
  logic [CAL_RAW_W-1:0]     high_raw_r;
  logic signed [TEMP_W-1:0] low_temp_r;
  logic signed [TEMP_W-1:0] high_temp_r;
  logic [THR_W-1:0]         threshold_r;

  int unsigned              taken_r;
  int unsigned              sum_r;
  logic [ADC_BITS-1:0]      min_r;
  logic [ADC_BITS-1:0]      max_r;
  logic signed [TEMP_W-1:0] last_reported_r;

  reading_t                 expected_readings[$];

  task automatic flag(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_block();
    taken_r = 0;
    sum_r   = 0;
    min_r   = '1;
    max_r   = '0;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
    case (cfg_reg_t'(idx))
      REG_SAMPLE_COUNT:  sample_count_r = val[SC_W-1:0];
      REG_CAL_LOW_RAW:   low_raw_r      = val[CAL_RAW_W-1:0];
      REG_CAL_LOW_TEMP:  low_temp_r     = val[TEMP_W-1:0];
      REG_CAL_HIGH_RAW:  high_raw_r     = val[CAL_RAW_W-1:0];
      REG_CAL_HIGH_TEMP: high_temp_r    = val[TEMP_W-1:0];
      REG_THRESHOLD:     threshold_r    = val[THR_W-1:0];
      default: ;
    endcase
  endfunction

  // Accumulate one sample; on the last sample of a block queue the reading.
  function automatic void fold_sample(input logic [ADC_BITS-1:0] s);
    int unsigned eff;
    int unsigned taken;
    int unsigned mean;
    longint      offset;
    longint      raw_span;
    longint      temp_span;
    longint      t;
    longint      change;
    reading_t    r;
    eff = 32'(sample_count_r);
    if (eff < MIN_COUNT) eff = MIN_COUNT;
    if (eff > MAX_SAMPLES) eff = MAX_SAMPLES;
    sum_r += 32'(s);
    if (s < min_r) min_r = s;
    if (s > max_r) max_r = s;
    taken = taken_r + 1;
    if (taken < eff) begin
      taken_r = taken;
      return;
    end
    mean = (sum_r - 32'(min_r) - 32'(max_r)) / (taken - 2);
    clear_block();
    r = '0;
    if (high_raw_r == low_raw_r) begin
      r.calibration_invalid = 1'b1;
      t = longint'(low_temp_r);
    end else begin
      offset    = longint'(mean) - longint'(low_raw_r);
      raw_span  = longint'(high_raw_r) - longint'(low_raw_r);
      temp_span = longint'(high_temp_r) - longint'(low_temp_r);
      t = longint'(low_temp_r) + (offset * temp_span) / raw_span;
      if (t > TEMP_MAX) begin
        t = TEMP_MAX;
        r.saturated = 1'b1;
      end
      if (t < TEMP_MIN) begin
        t = TEMP_MIN;
        r.saturated = 1'b1;
      end
    end
    change = t - longint'(last_reported_r);
    if (change < 0) change = -change;
    r.report = (change >= longint'(threshold_r));
    if (r.report) last_reported_r = t[TEMP_W-1:0];
    r.average_raw       = mean[OUT_RAW_W-1:0];
    r.temperature_centi = t[TEMP_W-1:0];
    expected_readings.push_back(r);
  endfunction

  task automatic check_reading();
    reading_t want;
    string    diffs;
    if (expected_readings.size() == 0) begin
      flag($sformatf("unexpected result average_raw=%0d temperature_centi=%0d",
                     average_raw, temperature_centi));
      return;
    end
    want  = expected_readings.pop_front();
    diffs = "";
    if (average_raw !== want.average_raw)
      diffs = {diffs, $sformatf(" average_raw %0d/%0d", average_raw, want.average_raw)};
    if (temperature_centi !== want.temperature_centi)
      diffs = {diffs, $sformatf(" temperature_centi %0d/%0d", temperature_centi,
                                $signed(want.temperature_centi))};
    if (report !== want.report)
      diffs = {diffs, $sformatf(" report %b/%b", report, want.report)};
    if (saturated !== want.saturated)
      diffs = {diffs, $sformatf(" saturated %b/%b", saturated, want.saturated)};
    if (calibration_invalid !== want.calibration_invalid)
      diffs = {diffs, $sformatf(" calibration_invalid %b/%b", calibration_invalid,
                                want.calibration_invalid)};
    if (diffs != "") flag({"result differs (got/expected):", diffs});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_count_r  = RST_SAMPLE_COUNT;
      low_raw_r       = RST_CAL_LOW_RAW;
      low_temp_r      = RST_CAL_LOW_TEMP;
      high_raw_r      = RST_CAL_HIGH_RAW;
      high_temp_r     = RST_CAL_HIGH_TEMP;
      threshold_r     = RST_THRESHOLD;
      last_reported_r = '0;
      clear_block();
      expected_readings.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) check_reading();
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) fold_sample(adc_sample);
    end
    outstanding = expected_readings.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tmth_pkg::*;

  localparam int MAX_SAMPLES   = 64;
  localparam int ADC_BITS      = 12;
  localparam int ADC_TOP       = (1 << ADC_BITS) - 1;
  localparam int COUNT_TOP     = (1 << SC_W) - 1;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 480;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [ADC_BITS-1:0]      adc_sample;
  logic                     out_valid;
  logic                     out_ready;
  logic [OUT_RAW_W-1:0]     average_raw;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic                     report;
  logic                     saturated;
  logic                     calibration_invalid;
  int unsigned              mismatches;
  int unsigned              outstanding;

  int unsigned              gap_pct;
  int unsigned              stall_pct;
  int unsigned              random_items;

  trimmed_mean_two_point_thermometer #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .ADC_BITS   (ADC_BITS)
  ) DUT (.*);

  thermo_checker #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .ADC_BITS   (ADC_BITS)
  ) reading_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [ADC_BITS-1:0] val);
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending, wait for every pending reading, then let the divider go idle.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_raw();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_DATA_W'(ADC_TOP);
      default: return CFG_DATA_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_temp();
    case ($urandom_range(5))
      0:       return TEMP_MIN;
      1:       return TEMP_MAX;
      2, 3:    return CFG_DATA_W'($urandom_range(1500, 3500));
      default: return CFG_DATA_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    case ($urandom_range(5))
      0:       return '0;
      1:       return {1'b0, {THR_W{1'b1}}};
      2:       return CFG_DATA_W'($urandom());
      default: return CFG_DATA_W'($urandom_range(40));
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  task automatic random_phase(input bit quiet);
    int unsigned            count;
    int unsigned            eff;
    int unsigned            items;
    int unsigned            mode;
    int                     center;
    int                     spread;
    int                     v;
    logic [CFG_DATA_W-1:0]  raw;
    settle();
    case ($urandom_range(15))
      0:       count = $urandom_range(2);
      1:       count = MAX_SAMPLES;
      2:       count = COUNT_TOP;
      3:       count = $urandom_range(13, COUNT_TOP);
      default: count = $urandom_range(3, 12);
    endcase
    if (quiet) count = $urandom_range(3, 8);
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(count));
    if ($urandom_range(7) == 0) begin
      raw = pick_raw();
      write_reg(REG_CAL_LOW_RAW, raw);
      write_reg(REG_CAL_HIGH_RAW, raw);
    end else begin
      if ($urandom_range(1)) write_reg(REG_CAL_LOW_RAW, pick_raw());
      if ($urandom_range(1)) write_reg(REG_CAL_HIGH_RAW, pick_raw());
    end
    if ($urandom_range(1)) write_reg(REG_CAL_LOW_TEMP, pick_temp());
    if ($urandom_range(1)) write_reg(REG_CAL_HIGH_TEMP, pick_temp());
    if ($urandom_range(1)) write_reg(REG_THRESHOLD, pick_threshold());

    eff = count < MIN_COUNT ? MIN_COUNT : (count > MAX_SAMPLES ? MAX_SAMPLES : count);
    if (quiet) begin
      gap_pct   = 0;
      stall_pct = 0;
      items     = 4 * eff;
    end else begin
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      items     = (eff > 16 ? 1 : $urandom_range(2, 6)) * eff + $urandom_range(eff - 1);
    end
    mode   = $urandom_range(3);
    center = $urandom_range(ADC_TOP);
    spread = $urandom_range(80);

    for (int i = 0; i < items; i++) begin
      case (mode)
        0: v = $urandom_range(ADC_TOP);
        3: v = $urandom_range(3) == 0 ? $urandom_range(ADC_TOP)
                                      : ($urandom_range(1) ? ADC_TOP : 0);
        default: begin
          if ($urandom_range(9) == 0) v = $urandom_range(ADC_TOP);
          else v = center + spread - int'($urandom_range(2 * spread));
          if (v < 0) v = 0;
          if (v > ADC_TOP) v = ADC_TOP;
        end
      endcase
      send_sample(v[ADC_BITS-1:0]);
    end
    if (!quiet) random_items += items;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = REG_SAMPLE_COUNT;
    cfg_data     = '0;
    in_valid     = 1'b0;
    adc_sample   = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    random_items = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration, field extremes in one block
    gap_pct   = 20;
    stall_pct = 20;
    send_sample(0);    send_sample(4095); send_sample(2048); send_sample(1);
    send_sample(4094); send_sample(3300); send_sample(3500); send_sample(3811);
    send_sample(3269); send_sample(4000);

    // equal calibration raws, count below minimum, zero threshold
    settle();
    write_reg(REG_SAMPLE_COUNT, 0);
    write_reg(REG_CAL_LOW_RAW, CFG_DATA_W'(ADC_TOP));
    write_reg(REG_CAL_HIGH_RAW, CFG_DATA_W'(ADC_TOP));
    write_reg(REG_THRESHOLD, 0);
    send_sample(100); send_sample(200); send_sample(300);

    // clipping at both ends of the temperature range
    settle();
    write_reg(REG_CAL_LOW_RAW, 0);
    write_reg(REG_CAL_HIGH_RAW, 1);
    write_reg(REG_CAL_LOW_TEMP, TEMP_MAX);
    write_reg(REG_CAL_HIGH_TEMP, TEMP_MIN);
    send_sample(4095); send_sample(4095); send_sample(4095);
    send_sample(0);    send_sample(0);    send_sample(0);
    settle();
    write_reg(REG_CAL_LOW_TEMP, TEMP_MIN);
    write_reg(REG_CAL_HIGH_TEMP, TEMP_MAX);
    send_sample(4095); send_sample(4094); send_sample(4093);

    // block size lowered below the samples already taken
    settle();
    write_reg(REG_SAMPLE_COUNT, 10);
    write_reg(REG_CAL_LOW_RAW, 1000);
    write_reg(REG_CAL_HIGH_RAW, 3000);
    write_reg(REG_CAL_LOW_TEMP, 0);
    write_reg(REG_CAL_HIGH_TEMP, 10000);
    write_reg(REG_THRESHOLD, 4);
    send_sample(1500); send_sample(2500); send_sample(1200); send_sample(2900);
    settle();
    write_reg(REG_SAMPLE_COUNT, 1);
    send_sample(2000);

    while (random_items < RANDOM_ITEMS) random_phase(1'b0);
    random_phase(1'b1);

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/tmth_pkg.sv
src/tmth_div.sv
src/trimmed_mean_two_point_thermometer.sv
src/tmth_chk.sv
sim/thermo_checker.sv
sim/tb.sv
